// ===== hdl/alt_pkg.sv =====
package alt_pkg;

    // Build-time limits of the tokenizer
    localparam int MAX_LINE_TOKENS  = 16;
    localparam int TOKEN_BUFFER_LEN = 32;

    localparam int CNT_W   = $clog2(MAX_LINE_TOKENS + 1);
    localparam int LEN_W   = $clog2(TOKEN_BUFFER_LEN);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LINE_TOKENS);
    localparam logic [LEN_W-1:0] LEN_CUT = LEN_W'(TOKEN_BUFFER_LEN - 1);

    // Results one input item can cause
    localparam int MAX_RESULTS = 3;
    localparam int RES_N_W     = 2;

    // Result queue; depth must be a power of two
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // Scan modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_TOKEN   = 2'd1;
    localparam logic [1:0] MODE_COMMENT = 2'd2;
    localparam logic [1:0] MODE_DROP    = 2'd3;

    // Special characters
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_char_valid;
        logic       line_last;
    } alt_in_t;

    typedef struct packed {
        logic [7:0] tok_char;
        logic       char_valid;
        logic       token_done;
        logic [3:0] token_number;
        logic       line_done;
    } alt_out_t;

    // Results of one item, handed from the scanner to the result queue
    typedef struct packed {
        alt_out_t [MAX_RESULTS-1:0] res;
        logic [RES_N_W-1:0]         n;
    } alt_push_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_LPAREN) || (c == CH_RPAREN);
    endfunction

    function automatic logic is_plain(input logic [7:0] c);
        return !is_blank(c) && (c != CH_SEMI) && (c != CH_COMMA) && !is_single(c);
    endfunction

endpackage

// ===== hdl/alt_scan.sv =====
module alt_scan (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  alt_pkg::alt_in_t item,
    output alt_pkg::alt_push_t push
);
    import alt_pkg::*;

    logic [1:0]       mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             exp_reg, exp_next;

    function automatic alt_out_t mk_res(input logic [7:0] ch, input logic cv,
                                        input logic done, input logic [CNT_W-1:0] cnt);
        alt_out_t r;
        r.tok_char     = ch;
        r.char_valid   = cv;
        r.token_done   = done;
        r.token_number = 4'(cnt);
        r.line_done    = 1'b0;
        return r;
    endfunction

    always_comb begin
        logic [1:0]       mode;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        logic             expv;
        logic [RES_N_W-1:0] n;
        alt_out_t [MAX_RESULTS-1:0] res;
        logic             do_idle;
        logic             do_add;
        logic             open;
        logic [7:0]       ch;

        mode    = mode_reg;
        len     = len_reg;
        cnt     = cnt_reg;
        expv    = exp_reg;
        n       = '0;
        res     = '0;
        do_idle = 1'b0;
        do_add  = 1'b0;
        open    = 1'b0;
        ch      = item.in_char;

        if (item.in_char_valid) begin
            case (mode)
                MODE_COMMENT: begin
                    do_add = 1'b1;
                end
                MODE_TOKEN: begin
                    if (is_plain(ch)) begin
                        do_add = 1'b1;
                    end else begin
                        // delimiter closes the open token with a bare mark
                        res[n]  = mk_res(8'h00, 1'b0, 1'b1, cnt);
                        n       = n + RES_N_W'(1);
                        cnt     = cnt + CNT_W'(1);
                        len     = '0;
                        mode    = MODE_IDLE;
                        do_idle = 1'b1;
                    end
                end
                MODE_IDLE: begin
                    do_idle = 1'b1;
                end
                default: begin
                end
            endcase

            if (do_idle) begin
                if (cnt >= MAX_CNT || is_blank(ch)) begin
                end else if (ch == CH_SEMI) begin
                    mode   = MODE_COMMENT;
                    len    = '0;
                    do_add = 1'b1;
                end else if (ch == CH_COMMA) begin
                    if (expv) begin
                        res[n] = mk_res(ch, 1'b1, 1'b1, cnt);
                        n      = n + RES_N_W'(1);
                        cnt    = cnt + CNT_W'(1);
                    end
                    expv = 1'b1;
                end else if (is_single(ch)) begin
                    res[n] = mk_res(ch, 1'b1, 1'b1, cnt);
                    n      = n + RES_N_W'(1);
                    cnt    = cnt + CNT_W'(1);
                    expv   = 1'b0;
                end else begin
                    expv   = 1'b0;
                    mode   = MODE_TOKEN;
                    len    = '0;
                    do_add = 1'b1;
                end
            end

            if (do_add) begin
                len = len + LEN_W'(1);
                if (len >= LEN_CUT) begin
                    // cut the token; a cut comment drops the rest of the line
                    res[n] = mk_res(ch, 1'b1, 1'b1, cnt);
                    n      = n + RES_N_W'(1);
                    cnt    = cnt + CNT_W'(1);
                    len    = '0;
                    mode   = (mode == MODE_COMMENT) ? MODE_DROP : MODE_IDLE;
                end else begin
                    res[n] = mk_res(ch, 1'b1, 1'b0, cnt);
                    n      = n + RES_N_W'(1);
                    open   = 1'b1;
                end
            end
        end

        if (item.line_last) begin
            if (mode == MODE_TOKEN || mode == MODE_COMMENT) begin
                if (open && n != '0) begin
                    res[n - RES_N_W'(1)].token_done = 1'b1;
                end else begin
                    res[n] = mk_res(8'h00, 1'b0, 1'b1, cnt);
                    n      = n + RES_N_W'(1);
                end
                cnt = cnt + CNT_W'(1);
            end
            if (expv && cnt < MAX_CNT) begin
                res[n] = mk_res(8'h00, 1'b0, 1'b1, cnt);
                n      = n + RES_N_W'(1);
                cnt    = cnt + CNT_W'(1);
            end
            if (n == '0) begin
                res[n] = mk_res(8'h00, 1'b0, 1'b0, cnt);
                n      = n + RES_N_W'(1);
            end
            res[n - RES_N_W'(1)].line_done = 1'b1;
            mode = MODE_IDLE;
            len  = '0;
            cnt  = '0;
            expv = 1'b0;
        end

        mode_next = mode;
        len_next  = len;
        cnt_next  = cnt;
        exp_next  = expv;
        push.res  = res;
        push.n    = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            len_reg  <= '0;
            cnt_reg  <= '0;
            exp_reg  <= 1'b0;
        end else if (step) begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            cnt_reg  <= cnt_next;
            exp_reg  <= exp_next;
        end
    end

endmodule

// ===== hdl/alt_rqueue.sv =====
module alt_rqueue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  alt_pkg::alt_push_t push,
    output logic               m_valid,
    input  logic               m_ready,
    output alt_pkg::alt_out_t  m_data
);
    import alt_pkg::*;

    alt_out_t            mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg;
    logic [RQ_PTR_W-1:0] rd_ptr_reg;
    logic [RQ_CNT_W-1:0] cnt_reg;
    logic                pop;
    logic                push_ok;
    logic [RQ_CNT_W:0]   fill_after;

    assign m_valid = (cnt_reg != '0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // room counts the slot freed by this cycle's pop
    assign fill_after = {1'b0, cnt_reg} + (RQ_CNT_W + 1)'(push.n);
    assign push_ready = fill_after <= (RQ_CNT_W + 1)'(RQ_DEPTH) + (RQ_CNT_W + 1)'(pop);
    assign push_ok    = push_valid && push_ready;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (push_ok && (RES_N_W + 1)'(i) < {1'b0, push.n}) begin
                mem_reg[wr_ptr_reg + RQ_PTR_W'(i)] <= push.res[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push_ok) begin
                wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(push.n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + RQ_PTR_W'(1);
            end
            cnt_reg <= cnt_reg + (push_ok ? RQ_CNT_W'(push.n) : '0) - RQ_CNT_W'(pop);
        end
    end

endmodule

// ===== hdl/assembly_line_tokenizer_core.sv =====
// Line tokenizer: splits source lines into token characters.
// Input channel (s_valid/s_ready/s_data) takes one request per cycle while s_ready
// is high: a byte with its valid flag and a line_last mark; a request with no byte and
// line_last set ends an empty line.
// Result channel (m_valid/m_ready/m_data) gives one result per cycle while results
// are queued and m_ready is high: a token character, a token_done mark closing the
// token, the token's index in the line, and line_done on the last result of the line.
// Path: a request is registered in the input register at acceptance, scanned from
// there, and its results are written to the result queue, which drives m_valid.
// Throughput: one request per cycle while each request yields one result and the
// receiver holds m_ready high; a request yields up to three results, and the result
// port drains one per cycle through a four-entry result queue, which sets the sustained rate.
// Reset (aresetn low, synchronous) empties the queue and the input register
// and returns the scanner to the idle state between lines.
// When the receiver stalls, the queue fills, the input register holds its
// request and s_ready drops until room for that request's results frees up.
module assembly_line_tokenizer_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  alt_pkg::alt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output alt_pkg::alt_out_t m_data
);
    import alt_pkg::*;

    logic      in_valid_reg;
    alt_in_t   in_reg;
    alt_push_t push;
    logic      push_ready;
    logic      step;

    assign step    = in_valid_reg && push_ready;
    assign s_ready = !in_valid_reg || push_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    alt_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_reg),
        .push    (push)
    );

    alt_rqueue u_rqueue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (in_valid_reg),
        .push_ready (push_ready),
        .push       (push),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
